// ===== rtl/core/midi_note_sustain_velocity_parser_top_assert.svh =====
// Assertion macros shared by the MIDI parser RTL.
`ifndef MIDI_NOTE_SUSTAIN_VELOCITY_PARSER_TOP_ASSERT_SVH
`define MIDI_NOTE_SUSTAIN_VELOCITY_PARSER_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define MSV_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define MSV_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/msv_pkg.sv =====
// ----------------------------------------------------------------------------
// msv_pkg
// Types and fixed codes of the MIDI note, sustain and velocity parser.
// ----------------------------------------------------------------------------
package msv_pkg;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_PEDAL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [6:0] PEDAL_CTRL = 7'd64;
    localparam logic [6:0] VEL_MAX    = 7'd127;

    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
    localparam logic [3:0] TYPE_CTRL     = 4'hB;
    localparam logic [3:0] TYPE_BEND     = 4'hE;

    // Commands from the front parser to the executor.
    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_REL = 2'd1;
    localparam logic [1:0] CMD_PEDAL    = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] key;
        logic [6:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [6:0] key_number;
        logic [6:0] level;
        logic       last_of_run;
    } t_result;

endpackage

// ===== rtl/core/msv_stream_if.sv =====
// ----------------------------------------------------------------------------
// msv_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface msv_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/msv_front.sv =====
// ----------------------------------------------------------------------------
// msv_front
// Running-status byte parser and command queue toward the executor.
// ----------------------------------------------------------------------------
module msv_front
    import msv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    `include "midi_note_sustain_velocity_parser_top_assert.svh"

    localparam int QD = 4;

    logic       r_phase;
    logic [3:0] r_type;
    logic [6:0] r_key;
    t_cmd       r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop, take, wants_val;
    t_cmd       n_cmd;
    logic [6:0] d7;

    assign o_ready     = (r_cnt != 3'(QD));
    assign take        = i_valid && o_ready;
    assign d7          = i_byte[6:0];
    assign wants_val   = (r_type == TYPE_NOTE_OFF) || (r_type == TYPE_NOTE_ON) ||
                         (r_type == TYPE_POLY_AT) || (r_type == TYPE_CTRL) ||
                         (r_type == TYPE_BEND);
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cmd.key   = r_key;
        n_cmd.value = d7;
        n_cmd.cmd   = CMD_NONE;
        if (r_type == TYPE_NOTE_ON) begin
            n_cmd.cmd = (d7 == 7'd0) ? CMD_NOTE_REL : CMD_NOTE_ON;
        end else if (r_type == TYPE_CTRL && r_key == PEDAL_CTRL) begin
            n_cmd.cmd = CMD_PEDAL;
        end
    end

    assign push = take && !i_byte[7] && r_phase && (n_cmd.cmd != CMD_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_type  <= 4'd0;
            r_key   <= 7'd0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (take) begin
                if (i_byte[7]) begin
                    r_type  <= i_byte[7:4];
                    r_phase <= 1'b0;
                end else if (!r_phase) begin
                    r_key   <= d7;
                    r_phase <= wants_val;
                end else begin
                    r_phase <= 1'b0;
                end
            end
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    `MSV_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, push, r_cnt != 3'(QD))
    `MSV_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, pop, r_cnt != 3'd0)
    `MSV_ASSERT_NEXT(a_status_resets_phase, i_clk, i_rst_n, take && i_byte[7], !r_phase)
endmodule

// ===== rtl/core/msv_back.sv =====
// ----------------------------------------------------------------------------
// msv_back
// Executes note and pedal commands: key map, velocity scaling, sustain list.
// ----------------------------------------------------------------------------
module msv_back
    import msv_pkg::*;
#(
    parameter int NUM_KEYS      = 88,
    parameter int LOWEST_KEY    = 21,
    parameter int SUSTAIN_DEPTH = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);
    `include "midi_note_sustain_velocity_parser_top_assert.svh"

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int SW = (SUSTAIN_DEPTH > 1) ? $clog2(SUSTAIN_DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_SREAD = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state      r_state;
    t_cmd        r_c;
    logic [NUM_KEYS-1:0] r_pressed, r_minv;  // r_minv: entry written
    logic [6:0]  r_mtab [NUM_KEYS];
    logic [6:0]  r_slist [SUSTAIN_DEPTH];
    logic [5:0]  r_scnt;
    logic [5:0]  r_si, r_sj;
    logic        r_pedal;
    logic [KW-1:0] r_idx;
    logic [6:0]  r_mn;
    logic [6:0]  r_rd;
    logic [6:0]  r_mrd;
    // restoring divider
    logic [13:0] r_num;
    logic [6:0]  r_den;
    logic [13:0] r_rem;
    logic [13:0] r_quo;
    logic [3:0]  r_dcnt;
    // output register
    logic        r_ov;
    t_result     r_out;

    logic        in_rng;
    logic [7:0]  koff;
    logic [6:0]  mn_rd, mn_new;
    logic [14:0] rem_sh;
    logic        out_free;

    assign out_free    = !r_ov || i_res_ready;
    assign o_res_valid = r_ov;
    assign o_res       = r_out;
    assign o_cmd_ready = (r_state == S_IDLE);

    assign koff   = {1'b0, r_c.key} - 8'(LOWEST_KEY);
    assign in_rng = ({1'b0, r_c.key} >= 8'(LOWEST_KEY)) &&
                    ({1'b0, r_c.key} < 8'(LOWEST_KEY + NUM_KEYS));
    assign mn_rd  = r_minv[r_idx] ? r_mrd : VEL_MAX;
    assign mn_new = (r_c.value < mn_rd) ? r_c.value : mn_rd;
    assign rem_sh = {r_rem, r_num[13]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pressed <= '0;
            r_minv    <= '0;
            r_scnt    <= '0;
            r_pedal   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_c     <= i_cmd;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idx <= KW'(koff);
                    if (r_c.cmd == CMD_PEDAL) begin
                        if (out_free) begin
                            r_ov              <= 1'b1;
                            r_out.event_kind  <= KIND_PEDAL;
                            r_out.key_number  <= PEDAL_CTRL;
                            r_out.level       <= r_c.value;
                            r_out.last_of_run <= (r_c.value != 7'd0) || (r_scnt == 6'd0);
                            r_pedal           <= (r_c.value != 7'd0);
                            r_si              <= '0;
                            r_state <= ((r_c.value != 7'd0) || (r_scnt == 6'd0)) ?
                                       S_IDLE : S_SREAD;
                        end
                    end else if (!in_rng) begin
                        if (r_c.cmd == CMD_NOTE_ON) begin
                            if (out_free) begin
                                r_ov              <= 1'b1;
                                r_out.event_kind  <= KIND_ERROR;
                                r_out.key_number  <= r_c.key;
                                r_out.level       <= 7'd0;
                                r_out.last_of_run <= 1'b1;
                                r_state           <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= (r_c.cmd == CMD_NOTE_ON) ? S_SREAD : S_EMIT;
                        r_si    <= '0;
                        r_sj    <= '0;
                    end
                end
                S_SCAN: begin
                    // compact the sustain list, dropping this key
                    if (r_si < r_scnt) begin
                        if (r_rd != r_c.key) begin
                            r_sj <= r_sj + 6'd1;
                        end
                        r_si    <= r_si + 6'd1;
                        r_state <= S_SREAD;
                    end else begin
                        r_scnt            <= r_sj;
                        r_pressed[r_idx]  <= 1'b1;
                        r_minv[r_idx]     <= 1'b1;
                        r_mn              <= mn_new;
                        r_num             <= {7'd0, r_c.value - mn_new} << 7;
                        r_den             <= VEL_MAX - mn_new;
                        r_rem             <= '0;
                        r_quo             <= '0;
                        r_dcnt            <= '0;
                        r_state           <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_mn == VEL_MAX) begin
                        r_quo   <= 14'd126;
                        r_state <= S_EMIT;
                    end else if (r_dcnt == 4'd14) begin
                        r_state <= S_EMIT;
                    end else begin
                        if (rem_sh >= {8'd0, r_den}) begin
                            r_rem <= 14'(rem_sh - {8'd0, r_den});
                            r_quo <= {r_quo[12:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[13:0];
                            r_quo <= {r_quo[12:0], 1'b0};
                        end
                        r_num  <= {r_num[12:0], 1'b0};
                        r_dcnt <= r_dcnt + 4'd1;
                    end
                end
                S_EMIT: begin
                    if (r_c.cmd == CMD_NOTE_ON) begin
                        if (out_free) begin
                            r_ov              <= 1'b1;
                            r_out.event_kind  <= KIND_NOTE;
                            r_out.key_number  <= r_c.key;
                            r_out.level       <= (r_quo >= 14'd126) ? VEL_MAX :
                                                 7'(r_quo + 14'd1);
                            r_out.last_of_run <= 1'b1;
                            r_state           <= S_IDLE;
                        end
                    end else if (!r_pressed[r_idx]) begin
                        r_state <= S_IDLE;
                    end else if (r_pedal && (r_scnt < 6'(SUSTAIN_DEPTH))) begin
                        r_pressed[r_idx] <= 1'b0;
                        r_scnt           <= r_scnt + 6'd1;
                        r_state          <= S_IDLE;
                    end else if (out_free) begin
                        r_pressed[r_idx]  <= 1'b0;
                        r_ov              <= 1'b1;
                        r_out.event_kind  <= KIND_NOTE;
                        r_out.key_number  <= r_c.key;
                        r_out.level       <= 7'd0;
                        r_out.last_of_run <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_SREAD: begin
                    // wait here while the list entry and the table word are registered
                    r_state <= (r_c.cmd == CMD_PEDAL) ? S_FLUSH : S_SCAN;
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_ov              <= 1'b1;
                        r_out.event_kind  <= KIND_NOTE;
                        r_out.key_number  <= r_rd;
                        r_out.level       <= 7'd0;
                        r_out.last_of_run <= (r_si + 6'd1 == r_scnt);
                        r_si              <= r_si + 6'd1;
                        if (r_si + 6'd1 == r_scnt) begin
                            r_scnt  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SREAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Memories: min velocity table and sustain list.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_si >= r_scnt) begin
            r_mtab[r_idx] <= mn_new;
        end
        if (r_state == S_SCAN && r_si < r_scnt && r_rd != r_c.key) begin
            r_slist[SW'(r_sj)] <= r_rd;
        end
        if (r_state == S_EMIT && r_c.cmd == CMD_NOTE_REL && r_pressed[r_idx] &&
            r_pedal && (r_scnt < 6'(SUSTAIN_DEPTH))) begin
            r_slist[SW'(r_scnt)] <= r_c.key;
        end
        r_rd  <= r_slist[SW'(r_si)];
        r_mrd <= r_mtab[r_idx];
    end

    `MSV_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_scnt <= 6'(SUSTAIN_DEPTH))
    `MSV_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_cmd_ready, r_state == S_IDLE)
    `MSV_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n,
        r_state == S_FLUSH && out_free && r_out.last_of_run == 1'b0 && r_si + 6'd1 == r_scnt,
        r_scnt == 6'd0)
endmodule

// ===== rtl/core/midi_note_sustain_velocity_parser_top.sv =====
// One byte is taken per cycle while the four-entry command queue has room; in the
// executor a note-on walks the sustain list to compact it and then runs a 14-step
// restoring divider, a pedal release emits one result per flushed key, and status
// or ignored bytes cost no executor time.
// ----------------------------------------------------------------------------
// midi_note_sustain_velocity_parser_top
// MIDI running-status parser with sustain pedal and velocity rescaling.
// ----------------------------------------------------------------------------
module midi_note_sustain_velocity_parser_top
    import msv_pkg::*;
#(
    parameter int NUM_KEYS      = 88,
    parameter int LOWEST_KEY    = 21,
    parameter int SUSTAIN_DEPTH = 63
) (
    input logic i_clk,
    input logic i_rst_n,
    msv_stream_if.sink   in_if,
    msv_stream_if.source out_if
);
    logic c_valid, c_ready;
    t_cmd c_cmd;
    t_result res;

    msv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_if.valid),
        .o_ready     (in_if.ready),
        .i_byte      (in_if.data),
        .o_cmd_valid (c_valid),
        .i_cmd_ready (c_ready),
        .o_cmd       (c_cmd)
    );

    msv_back #(
        .NUM_KEYS      (NUM_KEYS),
        .LOWEST_KEY    (LOWEST_KEY),
        .SUSTAIN_DEPTH (SUSTAIN_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (c_valid),
        .o_cmd_ready (c_ready),
        .i_cmd       (c_cmd),
        .o_res_valid (out_if.valid),
        .i_res_ready (out_if.ready),
        .o_res       (res)
    );

    assign out_if.data = res;
endmodule

// ===== bench/midi_note_sustain_velocity_parser_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_sustain_velocity_parser_top_test
// Drives MIDI byte streams into the parser and checks each result against an
// in-bench model of the note, pedal and velocity-scaling behavior.
// ----------------------------------------------------------------------------
module midi_note_sustain_velocity_parser_top_test;
    import msv_pkg::*;

    localparam int N_KEYS     = 88;
    localparam int KEY_LO     = 21;
    localparam int LIST_DEPTH = 63;
    localparam int DRAIN_WAIT = 400;
    localparam int STALL_MAX  = 20000;

    logic i_clk;
    logic i_rst_n;

    msv_stream_if #(.T(logic [7:0])) in_ch ();
    msv_stream_if #(.T(t_result))    out_ch ();

    midi_note_sustain_velocity_parser_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_ch),
        .out_if  (out_ch)
    );

    // Parser state mirror
    logic [3:0] run_type;
    logic       want_value;
    logic [6:0] key_latch;
    logic       pedal_on;
    logic       pressed [N_KEYS];
    logic [6:0] min_vel [N_KEYS];
    logic [6:0] held_list [LIST_DEPTH];
    int         held_cnt;

    t_result expected_events[$];
    int      errors;
    bit      idle_en;
    int      ready_hold;
    int      quiet_cycles;

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void push_event(input logic [1:0] kind, input logic [6:0] key,
                                       input logic [6:0] lvl);
        t_result r;
        r.event_kind  = kind;
        r.key_number  = key;
        r.level       = lvl;
        r.last_of_run = 1'b0;
        expected_events.push_back(r);
    endfunction

    function automatic void play_message(input logic [6:0] key, input logic [6:0] value);
        int idx;
        int mn;
        int lvl;
        int j;
        idx = int'(key) - KEY_LO;
        if (run_type == TYPE_NOTE_ON) begin
            if (idx < 0 || idx >= N_KEYS) begin
                if (value != 0) push_event(KIND_ERROR, key, 7'd0);
                return;
            end
            if (value == 0) begin
                if (!pressed[idx]) return;
                pressed[idx] = 1'b0;
                if (pedal_on && held_cnt < LIST_DEPTH) begin
                    held_list[held_cnt] = key;
                    held_cnt++;
                end else begin
                    push_event(KIND_NOTE, key, 7'd0);
                end
            end else begin
                // drop the key from the deferred list, keep order
                j = 0;
                for (int i = 0; i < held_cnt; i++) begin
                    if (held_list[i] != key) begin
                        held_list[j] = held_list[i];
                        j++;
                    end
                end
                held_cnt = j;
                pressed[idx] = 1'b1;
                if (value < min_vel[idx]) min_vel[idx] = value;
                mn = min_vel[idx];
                if (mn >= 127) lvl = 127;
                else begin
                    lvl = 1 + (int'(value) - mn) * 128 / (127 - mn);
                    if (lvl > 127) lvl = 127;
                end
                push_event(KIND_NOTE, key, 7'(lvl));
            end
        end else if (run_type == TYPE_CTRL && key == PEDAL_CTRL) begin
            push_event(KIND_PEDAL, PEDAL_CTRL, value);
            pedal_on = (value != 0);
            if (!pedal_on) begin
                for (int i = 0; i < held_cnt; i++) push_event(KIND_NOTE, held_list[i], 7'd0);
                held_cnt = 0;
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        int n_prior;
        n_prior = expected_events.size();
        if (b[7]) begin
            run_type   = b[7:4];
            want_value = 1'b0;
        end else if (!want_value) begin
            key_latch = b[6:0];
            if (run_type inside {TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_AT, TYPE_CTRL,
                                 TYPE_BEND})
                want_value = 1'b1;
        end else begin
            want_value = 1'b0;
            play_message(key_latch, b[6:0]);
            if (expected_events.size() > n_prior)
                expected_events[expected_events.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_byte(b);
    endtask

    task automatic send_msg(input logic [7:0] st, input logic [6:0] k, input logic [6:0] v);
        send_byte(st);
        send_byte({1'b0, k});
        send_byte({1'b0, v});
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        wait (expected_events.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_byte(8'h15);                     // running type zero: key byte ends it
        send_byte(8'h40);
        send_msg(8'h90, 7'd21, 7'd127);       // minimum 127 gives 127
        send_msg(8'h90, 7'd108, 7'd1);
        send_byte(8'h3C);                     // running status, key 60
        send_byte(8'h00);                     // release of a key not pressed
        send_msg(8'h90, 7'd20, 7'd50);        // below range: error
        send_msg(8'h90, 7'd109, 7'd50);       // above range: error
        send_msg(8'h90, 7'd127, 7'd0);        // out of range, velocity zero
        send_byte(8'h91);
        send_byte(8'h30);
        send_byte(8'hB0);                     // status mid-message drops it
        send_msg(8'hB0, 7'd64, 7'd127);
        send_msg(8'h90, 7'd21, 7'd0);         // deferred
        send_msg(8'h80, 7'd108, 7'd0);        // note-off type ignored
        send_msg(8'hB0, 7'd7, 7'd100);        // other controller ignored
        send_msg(8'hB0, 7'd64, 7'd0);         // flush
        send_byte(8'hA0); send_byte(8'h7F); send_byte(8'h7F);
        send_byte(8'hE0); send_byte(8'h00); send_byte(8'h55);
        send_byte(8'hFF); send_byte(8'h2A);
        wait_drained();
    endtask

    task automatic test_sustain_overflow();
        send_msg(8'hB5, 7'd64, 7'd1);
        send_byte(8'h92);
        // fill the deferred list, the last release goes out at once
        for (int k = 0; k < 64; k++) begin
            send_byte(8'(KEY_LO + k));
            send_byte(8'($urandom_range(1, 127)));
            send_byte(8'(KEY_LO + k));
            send_byte(8'h00);
        end
        send_msg(8'hB0, 7'd64, 7'd0);         // most results from one byte
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int sent;
        int k;
        sent = 0;
        while (sent < n_bytes) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent++;
                end
                1: begin
                    send_msg(8'hB0 | 8'($urandom_range(0, 15)), 7'd64,
                             $urandom_range(0, 3) == 0 ? 7'd0 : 7'($urandom_range(0, 127)));
                    sent += 3;
                end
                2: begin
                    send_byte({1'b1, 7'($urandom_range(0, 127))});
                    send_byte(8'($urandom_range(0, 127)));
                    sent += 2;
                end
                default: begin
                    send_byte(8'h90 | 8'($urandom_range(0, 15)));
                    sent++;
                    repeat ($urandom_range(1, 4)) begin
                        k = $urandom_range(0, 15) == 0 ? $urandom_range(0, 127)
                                                       : $urandom_range(KEY_LO, KEY_LO + 20);
                        send_byte(8'(k));
                        send_byte($urandom_range(0, 2) == 0 ? 8'h00
                                                            : 8'($urandom_range(0, 127)));
                        sent += 2;
                    end
                end
            endcase
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        ready_hold = 1500;
        for (int i = 0; i < 10; i++) send_msg(8'h93, 7'($urandom_range(KEY_LO, 108)),
                                             7'($urandom_range(1, 127)));
        wait_drained();
    endtask

    // Result checker and receiver stall
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int gap;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = expected_events.pop_front();
                if (got.event_kind !== want.event_kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              got.event_kind, want.event_kind));
                if (got.key_number !== want.key_number)
                    report_mismatch($sformatf("key_number %0d, want %0d",
                                              got.key_number, want.key_number));
                if (got.level !== want.level)
                    report_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              got.last_of_run, want.last_of_run));
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end else if (gap > 0) begin
            gap--;
            out_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = 8'h00;
        out_ch.ready = 1'b0;
        errors       = 0;
        idle_en      = 1'b1;
        ready_hold   = 0;
        quiet_cycles = 0;
        run_type     = 4'h0;
        want_value   = 1'b0;
        key_latch    = 7'd0;
        pedal_on     = 1'b0;
        held_cnt     = 0;
        for (int i = 0; i < N_KEYS; i++) begin
            pressed[i] = 1'b0;
            min_vel[i] = VEL_MAX;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_sustain_overflow();
        test_backpressure();
        test_random_traffic(40);
        idle_en = 1'b0;                       // last part runs at full rate
        test_random_traffic(20);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
